[rtl/usv_pkg.sv]
// shared types and constants for the utf-8 stream validator
package usv_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // lead bytes whose second byte gets an overlong check
    typedef enum logic [2:0] {
        LEAD_OTHER = 3'd0,
        LEAD_E0    = 3'd1,
        LEAD_F0    = 3'd2,
        LEAD_F8    = 3'd3,
        LEAD_FC    = 3'd4
    } lead_kind_t;

    // one classified request as it travels from front to back
    typedef struct packed {
        logic       has_byte;
        logic       end_of_string;
        logic       is_zero;
        logic       is_ascii;
        logic       is_cont;
        logic       lead_bad;
        logic [2:0] trail;
        lead_kind_t lead_kind;
        logic       low20;
        logic       low30;
        logic       low38;
        logic       low3c;
    } byte_class_t;

endpackage

[rtl/usv_front.sv]
// front end: takes byte requests and classifies each byte on its own
module usv_front (
    input  logic                 byte_valid,
    input  logic [7:0]           data_byte,
    input  logic                 has_byte,
    input  logic                 end_of_string,
    input  logic                 full,
    output logic                 push,
    output usv_pkg::byte_class_t cls
);

    always_comb
    begin
        push              = byte_valid && !full;
        cls.has_byte      = has_byte;
        cls.end_of_string = end_of_string;
        cls.is_zero       = (data_byte == 8'h00);
        cls.is_ascii      = !data_byte[7];
        cls.is_cont       = (data_byte[7:6] == 2'b10);
        // overlong two-byte lead, or one of the two leads that never occur
        cls.lead_bad      = (data_byte[7:1] == 7'b1100_000) || (data_byte[7:1] == 7'b1111_111);
        cls.low20         = ((data_byte & 8'h20) == 8'h00);
        cls.low30         = ((data_byte & 8'h30) == 8'h00);
        cls.low38         = ((data_byte & 8'h38) == 8'h00);
        cls.low3c         = ((data_byte & 8'h3c) == 8'h00);

        if (data_byte < 8'he0)
        begin
            cls.trail = 3'd1;
        end
        else if (data_byte < 8'hf0)
        begin
            cls.trail = 3'd2;
        end
        else if (data_byte < 8'hf8)
        begin
            cls.trail = 3'd3;
        end
        else if (data_byte < 8'hfc)
        begin
            cls.trail = 3'd4;
        end
        else
        begin
            cls.trail = 3'd5;
        end

        case (data_byte)
            8'he0:   cls.lead_kind = usv_pkg::LEAD_E0;
            8'hf0:   cls.lead_kind = usv_pkg::LEAD_F0;
            8'hf8:   cls.lead_kind = usv_pkg::LEAD_F8;
            8'hfc:   cls.lead_kind = usv_pkg::LEAD_FC;
            default: cls.lead_kind = usv_pkg::LEAD_OTHER;
        endcase
    end

endmodule

[rtl/usv_queue.sv]
// small queue of classified requests between front and back
module usv_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  usv_pkg::byte_class_t push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 empty,
    output usv_pkg::byte_class_t head
);

    usv_pkg::byte_class_t          mem [usv_pkg::QDEPTH];
    logic [usv_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [usv_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [usv_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [usv_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [usv_pkg::QCNT_W-1:0]    count_reg;
    logic [usv_pkg::QCNT_W-1:0]    count_next;

    assign full  = (count_reg == usv_pkg::QCNT_W'(usv_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == usv_pkg::QPTR_W'(usv_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == usv_pkg::QPTR_W'(usv_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/usv_back.sv]
// back end: sequence tracking, error flag and the result register
module usv_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  usv_pkg::byte_class_t head,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 string_valid
);

    logic [2:0]          pending_reg;
    logic [2:0]          pending_next;
    usv_pkg::lead_kind_t kind_reg;
    usv_pkg::lead_kind_t kind_next;
    logic                expect_reg;
    logic                expect_next;
    logic                err_reg;
    logic                err_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_flag_reg;
    logic                out_flag_next;
    logic                out_free;
    logic                sec_err;

    assign result_valid = out_valid_reg;
    assign string_valid = out_flag_reg;
    assign out_free     = !out_valid_reg || !result_stall;
    // only an end-of-string request needs room in the result register
    assign pop          = !empty && (!head.end_of_string || out_free);

    always_comb
    begin
        case (kind_reg)
            usv_pkg::LEAD_E0: sec_err = head.low20;
            usv_pkg::LEAD_F0: sec_err = head.low30;
            usv_pkg::LEAD_F8: sec_err = head.low38;
            usv_pkg::LEAD_FC: sec_err = head.low3c;
            default:          sec_err = 1'b0;
        endcase
    end

    always_comb
    begin
        pending_next   = pending_reg;
        kind_next      = kind_reg;
        expect_next    = expect_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_flag_next  = out_flag_reg;

        if (pop)
        begin
            if (head.has_byte)
            begin
                if (pending_reg == 3'd0)
                begin
                    if (head.is_zero)
                    begin
                        err_next = 1'b1;
                    end
                    else if (head.is_ascii)
                    begin
                        err_next = err_reg;
                    end
                    else if (head.is_cont)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        err_next     = err_reg || head.lead_bad;
                        kind_next    = head.lead_kind;
                        pending_next = head.trail;
                        expect_next  = 1'b1;
                    end
                end
                else
                begin
                    err_next = err_reg || !head.is_cont || (expect_reg && sec_err);
                    expect_next  = 1'b0;
                    pending_next = pending_reg - 3'd1;
                end
            end

            if (head.end_of_string)
            begin
                out_valid_next = 1'b1;
                out_flag_next  = !err_next && (pending_next == 3'd0);
                pending_next   = 3'd0;
                kind_next      = usv_pkg::LEAD_OTHER;
                expect_next    = 1'b0;
                err_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 3'd0;
            kind_reg      <= usv_pkg::LEAD_OTHER;
            expect_reg    <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            kind_reg      <= kind_next;
            expect_reg    <= expect_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_flag_reg <= out_flag_next;
    end

endmodule

[rtl/utf8_stream_validator.sv]
// top level of the utf-8 stream validator
// Takes one byte request per clock and gives one string_valid result per
// string, on the request that carries end_of_string. Sequences of one to six
// bytes are accepted; zero bytes, stray or malformed continuation bytes,
// overlong forms seen on the lead and second byte, leads FE/FF and strings
// that stop inside a sequence give 0, and an empty string gives 1. The front
// end writes each classified byte into a four-entry queue; the back end reads
// one entry per cycle unless a stalled result holds an end_of_string entry;
// a result passes the queue, then the result register. While the result side
// keeps up it sustains one request per cycle; byte_stall rises only when full.
module utf8_stream_validator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       end_of_string,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       string_valid
);

    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 empty;
    usv_pkg::byte_class_t cls;
    usv_pkg::byte_class_t head;

    assign byte_stall = full;

    usv_front u_front (
        .byte_valid    (byte_valid),
        .data_byte     (data_byte),
        .has_byte      (has_byte),
        .end_of_string (end_of_string),
        .full          (full),
        .push          (push),
        .cls           (cls)
    );

    usv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cls),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head)
    );

    usv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .string_valid (string_valid)
    );

endmodule
